[rtl/camera_packet_polar_converter_top_defines.svh]
// Assertion macros for the camera packet polar converter.
// No dependencies; included by the top level.
`ifndef CAMERA_PACKET_POLAR_CONVERTER_TOP_DEFINES_SVH
`define CAMERA_PACKET_POLAR_CONVERTER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CPPC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CPPC_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CPPC_ASSERT(label, clk, rst_n, prop, msg)
`define CPPC_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[rtl/cppc_pkg.sv]
// Package for the camera packet polar converter: types, constants, tables.
// No dependencies.
package cppc_pkg;

  localparam int unsigned CordicSteps = 19;
  localparam int unsigned ZW = 28;   // angle accumulator, 2^-16 degree units, signed
  localparam int unsigned XW = 32;   // CORDIC x/y width
  localparam logic [14:0] AngleZero = 15'd5760;
  localparam logic [14:0] FullCircle = 15'd23040;

  typedef enum logic [1:0] {PH_HUNT, PH_SECOND, PH_COLLECT} phase_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_SQRT, ST_CORDIC, ST_FINISH, ST_NEXT, ST_OUT
  } ctl_state_t;

  typedef enum logic [1:0] {REG_START, REG_ATTACK, REG_CENTER} cfg_reg_t;

  typedef struct packed {
    logic       load;     // latch offsets of object obj
    logic       step;     // run one iteration of sqrt and CORDIC
    logic       finish;   // store result of object obj
    logic [1:0] obj;      // object slot 0..2
  } dp_cmd_t;

  typedef struct packed {
    logic last_step;
  } dp_sts_t;

  typedef struct packed {
    logic        seen;
    logic [11:0] distance;
    logic [14:0] angle;
  } obj_res_t;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] i);
    case (i)
      5'd0:  atan_lut = 28'sd2949120;
      5'd1:  atan_lut = 28'sd1740967;
      5'd2:  atan_lut = 28'sd919879;
      5'd3:  atan_lut = 28'sd466945;
      5'd4:  atan_lut = 28'sd234379;
      5'd5:  atan_lut = 28'sd117304;
      5'd6:  atan_lut = 28'sd58666;
      5'd7:  atan_lut = 28'sd29335;
      5'd8:  atan_lut = 28'sd14668;
      5'd9:  atan_lut = 28'sd7334;
      5'd10: atan_lut = 28'sd3667;
      5'd11: atan_lut = 28'sd1833;
      5'd12: atan_lut = 28'sd917;
      5'd13: atan_lut = 28'sd458;
      5'd14: atan_lut = 28'sd229;
      5'd15: atan_lut = 28'sd115;
      5'd16: atan_lut = 28'sd57;
      5'd17: atan_lut = 28'sd29;
      5'd18: atan_lut = 28'sd14;
      default: atan_lut = 28'sd0;
    endcase
  endfunction

endpackage

[rtl/cppc_if.sv]
// Valid/ready channel interfaces for the converter.
// Depends on nothing; payload types are plain vectors.
interface cppc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface cppc_out_if;
  logic        valid;
  logic        ready;
  logic        ball_seen;
  logic [11:0] ball_distance;
  logic [14:0] ball_angle;
  logic        attack_seen;
  logic [11:0] attack_distance;
  logic [14:0] attack_angle;
  logic        defend_seen;
  logic [11:0] defend_distance;
  logic [14:0] defend_angle;
  modport source (output valid, output ball_seen, output ball_distance, output ball_angle,
                  output attack_seen, output attack_distance, output attack_angle,
                  output defend_seen, output defend_distance, output defend_angle,
                  input ready);
  modport sink (input valid, input ball_seen, input ball_distance, input ball_angle,
                input attack_seen, input attack_distance, input attack_angle,
                input defend_seen, input defend_distance, input defend_angle,
                output ready);
endinterface

interface cppc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] addr;
  logic [7:0] data;
  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

[rtl/cppc_datapath.sv]
// Datapath: offsets, shared bit-serial square root and CORDIC, result regs.
// Depends on cppc_pkg.
module cppc_datapath
  import cppc_pkg::*;
(
  input  logic       clk,
  input  dp_cmd_t    cmd,
  output dp_sts_t    sts,
  input  logic [7:0] center,
  input  logic [7:0] cx,
  input  logic [7:0] cy,
  output obj_res_t   res [3]
);

  logic signed [7:0]    dx_r, dy_r;
  logic                 seen_r, zero_r;
  logic [4:0]           it_r;
  logic [23:0]          sq_n_r;     // radicand sum*256, two bits taken per step
  logic [22:0]          sq_rem_r;   // partial remainder
  logic [11:0]          sq_root_r;
  logic signed [XW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  obj_res_t             res_r [3];

  logic signed [7:0]    dx_c, dy_c;
  logic signed [15:0]   dxw_c, dyw_c;
  logic [15:0]          sum_c;
  logic [13:0]          trial_c;
  logic [22:0]          rem_sh_c;
  logic signed [XW-1:0] xs_c, ys_c, ax_c, ay_c;
  logic signed [ZW-1:0] v_c;
  logic [17:0]          q_c;

  assign dx_c  = center - cx;
  assign dy_c  = center - cy;
  assign dxw_c = 16'(dx_c);
  assign dyw_c = 16'(dy_c);
  assign sum_c = 16'($unsigned(dxw_c * dxw_c)) + 16'($unsigned(dyw_c * dyw_c));
  assign sts.last_step = (it_r == 5'(CordicSteps - 1));

  // digit-by-digit root: 12 result bits from sum*256 (24 bits)
  assign rem_sh_c = {sq_rem_r[20:0], sq_n_r[23:22]};
  assign trial_c  = {sq_root_r, 2'b01};
  assign xs_c = x_r >>> it_r;
  assign ys_c = y_r >>> it_r;
  assign ax_c = XW'(dx_c) <<< 20;
  assign ay_c = XW'(dy_c) <<< 20;

  always_comb begin
    v_c = 28'sd5898240 - z_r;
    if (v_c < 0) v_c = v_c + 28'sd23592960;
    q_c = 18'((v_c + 28'sd512) >>> 10);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx_r      <= dx_c;
      dy_r      <= dy_c;
      seen_r    <= (cx != center) || (cy != center);
      zero_r    <= (dx_c == 0) && (dy_c == 0);
      it_r      <= '0;
      sq_n_r    <= {sum_c, 8'd0};
      sq_rem_r  <= '0;
      sq_root_r <= '0;
      if (dx_c < 0) begin
        if (dy_c >= 0) begin
          x_r <= ay_c; y_r <= -ax_c; z_r <= 28'sd5898240;
        end else begin
          x_r <= -ay_c; y_r <= ax_c; z_r <= -28'sd5898240;
        end
      end else begin
        x_r <= ax_c; y_r <= ay_c; z_r <= '0;
      end
    end else if (cmd.step) begin
      it_r <= it_r + 5'd1;
      if (it_r < 5'd12) begin
        sq_n_r <= {sq_n_r[21:0], 2'b00};
        if (rem_sh_c >= 23'(trial_c)) begin
          sq_rem_r  <= rem_sh_c - 23'(trial_c);
          sq_root_r <= {sq_root_r[10:0], 1'b1};
        end else begin
          sq_rem_r  <= rem_sh_c;
          sq_root_r <= {sq_root_r[10:0], 1'b0};
        end
      end
      if (y_r > 0) begin
        x_r <= x_r + ys_c; y_r <= y_r - xs_c; z_r <= z_r + atan_lut(it_r);
      end else begin
        x_r <= x_r - ys_c; y_r <= y_r + xs_c; z_r <= z_r - atan_lut(it_r);
      end
    end
    if (cmd.finish) begin
      res_r[cmd.obj].seen     <= seen_r;
      res_r[cmd.obj].distance <= sq_root_r;
      if (zero_r) res_r[cmd.obj].angle <= AngleZero;
      else if (q_c >= 18'(FullCircle)) res_r[cmd.obj].angle <= '0;
      else res_r[cmd.obj].angle <= q_c[14:0];
    end
  end

  assign res = res_r;

endmodule

[rtl/cppc_ctrl.sv]
// Controller: packet framing and sequencing of the three object conversions.
// Depends on cppc_pkg.
module cppc_ctrl
  import cppc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [7:0] rx_byte,
  input  logic [7:0] start_byte,
  input  logic       out_fire,
  input  dp_sts_t    sts,
  output dp_cmd_t    cmd,
  output logic       busy,
  output logic       out_valid,
  output logic [2:0] wr_idx,
  output logic       wr_en
);

  phase_t     phase_r, phase_nxt;
  logic [2:0] idx_r, idx_nxt;
  ctl_state_t st_r, st_nxt;
  logic [1:0] obj_r, obj_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      idx_r   <= '0;
      st_r    <= ST_IDLE;
      obj_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      st_r    <= st_nxt;
      obj_r   <= obj_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    st_nxt    = st_r;
    obj_nxt   = obj_r;
    cmd       = '0;
    cmd.obj   = obj_r;
    wr_en     = 1'b0;
    wr_idx    = idx_r;
    case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (phase_r)
            PH_COLLECT: begin
              wr_en = 1'b1;
              if (idx_r == 3'd5) begin
                phase_nxt = PH_HUNT;
                idx_nxt   = '0;
                obj_nxt   = '0;
                st_nxt    = ST_LOAD;
              end else begin
                idx_nxt = idx_r + 3'd1;
              end
            end
            PH_SECOND: begin
              phase_nxt = (rx_byte == start_byte) ? PH_COLLECT : PH_HUNT;
              idx_nxt   = '0;
            end
            default: begin
              phase_nxt = (rx_byte == start_byte) ? PH_SECOND : PH_HUNT;
              idx_nxt   = '0;
            end
          endcase
        end
      end
      ST_LOAD: begin
        cmd.load = 1'b1;
        st_nxt   = ST_CORDIC;
      end
      ST_CORDIC: begin
        cmd.step = 1'b1;
        if (sts.last_step) st_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        st_nxt     = ST_NEXT;
      end
      ST_NEXT: begin
        if (obj_r == 2'd2) st_nxt = ST_OUT;
        else begin
          obj_nxt = obj_r + 2'd1;
          st_nxt  = ST_LOAD;
        end
      end
      ST_OUT: begin
        if (out_fire) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign busy      = (st_r != ST_IDLE);
  assign out_valid = (st_r == ST_OUT);

endmodule

[rtl/camera_packet_polar_converter_top.sv]
// Top level of the camera packet polar converter.
// Depends on cppc_pkg, cppc_if, cppc_ctrl, cppc_datapath and the defines header.
//
//  channel  dir  handshake     payload
//  in_      in   valid/ready   rx_byte
//  out_     out  valid/ready   seen/distance/angle for ball, attack, defend
//  cfg_     in   valid/ready   addr (register index), data
//
// A byte that does not finish a packet is taken in the same cycle that it is offered. The sixth
// coordinate byte starts the conversion of the three objects in turn, each by the
// shared 19-step CORDIC, with the 12-step root running in the same steps.
// in_ready is low from then until the result item is taken; out_valid holds.
// rst_n is synchronous; it clears framing, sequencing and the config registers,
// not the coordinate data or the results.
`include "camera_packet_polar_converter_top_defines.svh"
module camera_packet_polar_converter_top
  import cppc_pkg::*;
(
  input logic  clk,
  input logic  rst_n,
  cppc_in_if.sink    in_ch,
  cppc_out_if.source out_ch,
  cppc_cfg_if.sink   cfg_ch
);

  logic [7:0] start_byte_r, center_r;
  logic       attack_is_blue_r;
  logic [7:0] coord_r [6];
  dp_cmd_t    cmd;
  dp_sts_t    sts;
  obj_res_t   res [3];
  logic       busy, out_valid, wr_en, in_fire, out_fire;
  logic [2:0] wr_idx;
  logic [2:0] cx_i, cy_i;

  assign in_ch.ready  = !busy;
  assign cfg_ch.ready = 1'b1;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r     <= 8'd255;
      attack_is_blue_r <= 1'b0;
      center_r         <= 8'd120;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.addr)
        REG_START:  start_byte_r     <= cfg_ch.data;
        REG_ATTACK: attack_is_blue_r <= cfg_ch.data[0];
        REG_CENTER: center_r         <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // coordinate bytes, no reset needed
  always_ff @(posedge clk) begin
    if (wr_en) coord_r[wr_idx] <= in_ch.rx_byte;
  end

  // slot 0 ball, slot 1 attacked goal, slot 2 defended goal
  always_comb begin
    case (cmd.obj)
      2'd0: cx_i = 3'd0;
      2'd1: cx_i = attack_is_blue_r ? 3'd4 : 3'd2;
      default: cx_i = attack_is_blue_r ? 3'd2 : 3'd4;
    endcase
    cy_i = cx_i + 3'd1;
  end

  cppc_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .rx_byte(in_ch.rx_byte), .start_byte(start_byte_r),
    .out_fire, .sts, .cmd, .busy, .out_valid, .wr_idx, .wr_en
  );

  cppc_datapath u_dp (
    .clk, .cmd, .sts, .center(center_r), .cx(coord_r[cx_i]), .cy(coord_r[cy_i]), .res
  );

  assign out_ch.valid           = out_valid;
  assign out_ch.ball_seen       = res[0].seen;
  assign out_ch.ball_distance   = res[0].distance;
  assign out_ch.ball_angle      = res[0].angle;
  assign out_ch.attack_seen     = res[1].seen;
  assign out_ch.attack_distance = res[1].distance;
  assign out_ch.attack_angle    = res[1].angle;
  assign out_ch.defend_seen     = res[2].seen;
  assign out_ch.defend_distance = res[2].distance;
  assign out_ch.defend_angle    = res[2].angle;

  `CPPC_ASSERT(a_no_in_while_out, clk, rst_n, out_valid |-> !in_ch.ready, "input taken during output")
  `CPPC_ASSERT(a_out_holds, clk, rst_n, (out_valid && !out_ch.ready) |=> out_valid, "result dropped")
  `CPPC_ASSERT(a_cmd_excl, clk, rst_n, !(cmd.load && cmd.step), "load and step together")

endmodule
